// File: hdl/summed_area_table_engine_top_defines.svh
// Assertion macros shared by the summed-area table engine.
// No dependencies.
`ifndef SUMMED_AREA_TABLE_ENGINE_TOP_DEFINES_SVH
`define SUMMED_AREA_TABLE_ENGINE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SAT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hdl/sat_pkg.sv
// Shared types and constants for the summed-area table engine.
// No dependencies.
package sat_pkg;
  localparam int MaxRows   = 64;
  localparam int MaxCols   = 64;
  localparam int ElemWidth = 16;
  localparam int SumWidth  = 28;
  localparam int DimWidth  = 7;
  localparam int RowIdxW   = $clog2(MaxRows);
  localparam int ColIdxW   = $clog2(MaxCols);
  localparam int AddrW     = RowIdxW + ColIdxW;
  localparam int Cells     = MaxRows * MaxCols;
  localparam int QDepth    = 2;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NOTBLT = 2'd2;

  typedef enum logic [1:0] {OP_DONE, OP_LOAD, OP_BUILD, OP_QUERY} op_t;

  // Classified item passed from front to back
  typedef struct packed {
    op_t                        op;
    logic [1:0]                 status;
    logic [RowIdxW-1:0]         r_lo;
    logic [ColIdxW-1:0]         c_lo;
    logic [RowIdxW-1:0]         r_hi;
    logic [ColIdxW-1:0]         c_hi;
    logic                       r_lo_z;
    logic                       c_lo_z;
    logic signed [ElemWidth-1:0] value;
  } cmd_t;
endpackage

// File: hdl/summed_area_table_engine_top.sv
// Summed-area table engine top: config registers, front end, back end.
// Throughput: one item at a time through the back end; the two-entry queue lets
// start be taken while the back end works (busy when the queue is full).
// Reset clears controls, then a pass over all 4096 entries zeroes the raw store;
// busy is high meanwhile. Results are strobed on out_valid for one cycle.
// Depends on sat_pkg.
module summed_area_table_engine_top import sat_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [6:0]         in_row_a,
  input  logic [6:0]         in_col_a,
  input  logic [6:0]         in_row_b,
  input  logic [6:0]         in_col_b,
  input  logic signed [15:0] in_elem_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_wdata,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [27:0] out_rect_sum
);
  logic [DimWidth-1:0] rows_r, cols_r, nr, nc;
  logic q_full, q_empty, q_pop, built, clearing;
  cmd_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DimWidth'(MaxRows);
      cols_r <= DimWidth'(MaxCols);
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) rows_r <= cfg_wdata;
      else cols_r <= cfg_wdata;
    end
  end

  // Effective dimensions
  always_comb begin
    nr = (rows_r == '0) ? 7'd1 : (rows_r > 7'(MaxRows) ? 7'(MaxRows) : rows_r);
    nc = (cols_r == '0) ? 7'd1 : (cols_r > 7'(MaxCols) ? 7'(MaxCols) : cols_r);
  end

  assign busy = q_full || clearing;

  sat_front u_front (
    .clk, .rst_n,
    .in_valid(start && !busy),
    .in_req_type, .in_row_a, .in_col_a, .in_row_b, .in_col_b, .in_elem_value,
    .nr, .nc, .built,
    .q_full, .q_empty, .q_head, .q_pop
  );

  sat_back u_back (
    .clk, .rst_n, .nr, .nc, .q_empty, .q_head, .q_pop, .built, .clearing,
    .out_valid, .out_status, .out_rect_sum
  );
endmodule

// File: hdl/sat_front.sv
// Front end: accepts items, checks ranges and build state, swaps corners, queues commands.
// Depends on sat_pkg.
module sat_front import sat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_req_type,
  input  logic [6:0]           in_row_a,
  input  logic [6:0]           in_col_a,
  input  logic [6:0]           in_row_b,
  input  logic [6:0]           in_col_b,
  input  logic signed [15:0]   in_elem_value,
  input  logic [DimWidth-1:0]  nr,
  input  logic [DimWidth-1:0]  nc,
  input  logic                 built,
  output logic                 q_full,
  output logic                 q_empty,
  output cmd_t                 q_head,
  input  logic                 q_pop
);
  cmd_t cmd;
  logic [6:0] rl, rh, cl, ch;
  cmd_t q_r [QDepth];
  logic [$clog2(QDepth)-1:0] wp_r, rp_r;
  logic [$clog2(QDepth):0] cnt_r;
  logic push, built_pend;
  logic built_seen_r;

  // Classification
  always_comb begin
    rl = (in_row_a > in_row_b) ? in_row_b : in_row_a;
    rh = (in_row_a > in_row_b) ? in_row_a : in_row_b;
    cl = (in_col_a > in_col_b) ? in_col_b : in_col_a;
    ch = (in_col_a > in_col_b) ? in_col_a : in_col_b;
    cmd = '0;
    cmd.value = in_elem_value;
    cmd.op = OP_DONE;
    cmd.status = ST_OK;
    case (in_req_type)
      REQ_LOAD: begin
        if (in_row_a == '0 || in_col_a == '0 || in_row_a > nr || in_col_a > nc) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.op = OP_LOAD;
          cmd.r_lo = RowIdxW'(in_row_a - 7'd1);
          cmd.c_lo = ColIdxW'(in_col_a - 7'd1);
        end
      end
      REQ_BUILD: cmd.op = OP_BUILD;
      REQ_QUERY: begin
        if (rl == '0 || cl == '0 || rh > nr || ch > nc) begin
          cmd.status = ST_RANGE;
        end else if (!built_pend) begin
          cmd.status = ST_NOTBLT;
        end else begin
          cmd.op = OP_QUERY;
          cmd.r_lo_z = (rl == 7'd1);
          cmd.c_lo_z = (cl == 7'd1);
          cmd.r_lo = RowIdxW'(rl - 7'd2);
          cmd.c_lo = ColIdxW'(cl - 7'd2);
          cmd.r_hi = RowIdxW'(rh - 7'd1);
          cmd.c_hi = ColIdxW'(ch - 7'd1);
        end
      end
      default: cmd.op = OP_DONE;
    endcase
  end

  // Any build already taken counts as built for later queries
  assign built_pend = built || built_seen_r;

  assign push    = in_valid;
  assign q_full  = (cnt_r == ($clog2(QDepth)+1)'(QDepth));
  assign q_empty = (cnt_r == '0);
  assign q_head  = q_r[rp_r];

  // Command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      built_seen_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(q_pop);
      if (push && in_req_type == REQ_BUILD) built_seen_r <= 1'b1;
    end
    if (push) q_r[wp_r] <= cmd;
  end
endmodule

// File: hdl/sat_back.sv
// Back end: raw and prefix memories, build sweep, query combine, result.
// Depends on sat_pkg and the assertion macro header.
`include "summed_area_table_engine_top_defines.svh"
module sat_back import sat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [DimWidth-1:0]  nr,
  input  logic [DimWidth-1:0]  nc,
  input  logic                 q_empty,
  input  cmd_t                 q_head,
  output logic                 q_pop,
  output logic                 built,
  output logic                 clearing,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic signed [27:0]   out_rect_sum
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_B_RD, S_B_WAIT, S_B_ACC, S_Q_RD, S_Q_ACC, S_Q_END
  } state_t;

  typedef logic signed [SumWidth-1:0] sum_t;

  state_t state_r;
  logic signed [ElemWidth-1:0] raw_mem [Cells];
  sum_t pre_mem [Cells];
  logic [AddrW-1:0] clr_r;
  logic [RowIdxW-1:0] r_r;
  logic [ColIdxW-1:0] c_r;
  logic [1:0] k_r;
  logic built_r, clearing_r;
  sum_t acc_r, rowsum_r, pre_q;
  logic signed [ElemWidth-1:0] raw_q;
  cmd_t cmd_r;
  logic [AddrW-1:0] raw_addr, pre_raddr;
  logic raw_we, pre_we;
  logic signed [ElemWidth-1:0] raw_wd;
  logic pre_zero_r, pre_zero;
  logic out_valid_r;
  logic [1:0] out_status_r;
  sum_t out_sum_r;
  logic [RowIdxW-1:0] qr;
  logic [ColIdxW-1:0] qc;
  logic qz;

  assign built = built_r;
  assign clearing = clearing_r;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_rect_sum = out_sum_r;
  assign q_pop = (state_r == S_IDLE) && !q_empty;

  // Query corner select: k=0 (hi,hi) +, 1 (lo,hi) -, 2 (hi,lo) -, 3 (lo,lo) +
  always_comb begin
    qr = k_r[0] ? cmd_r.r_lo : cmd_r.r_hi;
    qc = k_r[1] ? cmd_r.c_lo : cmd_r.c_hi;
    qz = (k_r[0] && cmd_r.r_lo_z) || (k_r[1] && cmd_r.c_lo_z);
  end

  // Memory ports
  always_comb begin
    raw_we = 1'b0;
    raw_wd = '0;
    raw_addr = {r_r, c_r};
    pre_raddr = {r_r - 1'b1, c_r};
    pre_we = 1'b0;
    if (state_r == S_CLEAR) begin
      raw_we = 1'b1;
      raw_addr = clr_r;
    end else if (state_r == S_IDLE && !q_empty && q_head.op == OP_LOAD) begin
      raw_we = 1'b1;
      raw_addr = {q_head.r_lo, q_head.c_lo};
      raw_wd = q_head.value;
    end
    if (state_r == S_Q_RD) pre_raddr = {qr, qc};
    if (state_r == S_B_ACC) pre_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[raw_addr] <= raw_wd;
    raw_q <= raw_mem[raw_addr];
    if (pre_we) pre_mem[{r_r, c_r}] <= acc_r;
    pre_q <= pre_mem[pre_raddr];
  end

  // Build: acc = rowsum + raw + above; rowsum carries this row's running sum
  always_comb pre_zero = (state_r == S_Q_RD) ? qz : (r_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      clearing_r <= 1'b1;
      built_r <= 1'b0;
      out_valid_r <= 1'b0;
      r_r <= '0;
      c_r <= '0;
      k_r <= '0;
    end else begin
      out_valid_r <= 1'b0;
      pre_zero_r <= pre_zero;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AddrW'(Cells - 1)) begin
            state_r <= S_IDLE;
            clearing_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_head;
            r_r <= '0;
            c_r <= '0;
            k_r <= '0;
            acc_r <= '0;
            rowsum_r <= '0;
            case (q_head.op)
              OP_BUILD: state_r <= S_B_RD;
              OP_QUERY: state_r <= S_Q_RD;
              default: begin
                out_valid_r <= 1'b1;
                out_status_r <= q_head.status;
                out_sum_r <= '0;
              end
            endcase
          end
        end
        S_B_RD: state_r <= S_B_WAIT;
        S_B_WAIT: begin
          acc_r <= rowsum_r + sum_t'(raw_q) + (pre_zero_r ? sum_t'(0) : pre_q);
          rowsum_r <= rowsum_r + sum_t'(raw_q);
          state_r <= S_B_ACC;
        end
        S_B_ACC: begin
          if (7'(c_r) + 7'd1 >= nc) begin
            c_r <= '0;
            rowsum_r <= '0;
            if (7'(r_r) + 7'd1 >= nr) begin
              built_r <= 1'b1;
              out_valid_r <= 1'b1;
              out_status_r <= ST_OK;
              out_sum_r <= '0;
              state_r <= S_IDLE;
            end else begin
              r_r <= r_r + 1'b1;
              state_r <= S_B_RD;
            end
          end else begin
            c_r <= c_r + 1'b1;
            state_r <= S_B_RD;
          end
        end
        S_Q_RD: state_r <= S_Q_ACC;
        S_Q_ACC: begin
          if (!pre_zero_r) begin
            acc_r <= (k_r == 2'd1 || k_r == 2'd2) ? acc_r - pre_q : acc_r + pre_q;
          end
          k_r <= k_r + 1'b1;
          state_r <= (k_r == 2'd3) ? S_Q_END : S_Q_RD;
        end
        S_Q_END: begin
          out_valid_r <= 1'b1;
          out_status_r <= ST_OK;
          out_sum_r <= acc_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SAT_ASSERT_IMPL(a_no_pop_clear, clearing_r, !q_pop, "queue popped during clear")
  `SAT_ASSERT_NEXT(a_built_sticky, built_r, built_r, "built flag dropped")
  `SAT_ASSERT_NEXT(a_qend_out, state_r == S_Q_END, out_valid_r, "query result missing")
endmodule

// File: tb/summed_area_table_engine_top_tb.sv
// Testbench for summed_area_table_engine_top: directed table, then random phases
// of loads, builds and rectangle queries checked against an in-bench predictor.
// Depends on sat_pkg and the engine RTL.
`timescale 1ns / 100ps

module summed_area_table_engine_top_tb;
  import sat_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;
  localparam int IDLE_LIMIT = 60000;
  localparam int PHASES = 13;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic [1:0]         kind;
    logic [6:0]         ra, ca, rb, cb;
    logic signed [15:0] val;
    bit                 typed;
    logic [1:0]         st;
    logic signed [27:0] sum;
  } req_t;

  typedef struct {
    logic [1:0]         st;
    logic signed [27:0] sum;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [6:0] in_row_a = '0, in_col_a = '0, in_row_b = '0, in_col_b = '0;
  logic signed [15:0] in_elem_value = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [27:0] out_rect_sum;

  summed_area_table_engine_top u_dut (.*);

  always #10 clk = ~clk;

  // Predictor state
  logic signed [15:0] elem_mem[MaxRows][MaxCols];
  logic signed [27:0] prefix_mem[MaxRows][MaxCols];
  bit table_ready;
  logic [6:0] rows_reg, cols_reg;

  req_t cur_req;
  result_t sum_q[$];
  int n_accepted;
  int idle_cycles;
  bit failed;

  function automatic int eff_dim(logic [6:0] v);
    if (v == 0) return 1;
    return (v > 64) ? 64 : int'(v);
  endfunction

  function automatic logic signed [27:0] prefix_at(int r, int c);
    if (r == 0 || c == 0) return '0;
    return prefix_mem[r-1][c-1];
  endfunction

  function automatic result_t predict_rect(req_t q);
    result_t res;
    int nr, nc, r0, c0, r1, c1;
    res.st = ST_OK;
    res.sum = '0;
    nr = eff_dim(rows_reg);
    nc = eff_dim(cols_reg);
    case (q.kind)
      REQ_LOAD: begin
        if (q.ra == 0 || q.ca == 0 || q.ra > nr || q.ca > nc) res.st = ST_RANGE;
        else elem_mem[q.ra-1][q.ca-1] = q.val;
      end
      REQ_BUILD: begin
        for (int r = 1; r <= nr; r++)
          for (int c = 1; c <= nc; c++)
            prefix_mem[r-1][c-1] = 28'(elem_mem[r-1][c-1]) + prefix_at(r-1, c)
                                   + prefix_at(r, c-1) - prefix_at(r-1, c-1);
        table_ready = 1'b1;
      end
      REQ_QUERY: begin
        r0 = (q.ra < q.rb) ? q.ra : q.rb;
        r1 = (q.ra < q.rb) ? q.rb : q.ra;
        c0 = (q.ca < q.cb) ? q.ca : q.cb;
        c1 = (q.ca < q.cb) ? q.cb : q.ca;
        if (r0 == 0 || c0 == 0 || r1 > nr || c1 > nc) res.st = ST_RANGE;
        else if (!table_ready) res.st = ST_NOTBLT;
        else res.sum = prefix_at(r1, c1) - prefix_at(r0-1, c1)
                       - prefix_at(r1, c0-1) + prefix_at(r0-1, c0-1);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Accept, predict and check on the rising edge
  always @(posedge clk) begin
    result_t res, want;
    if (!rst_n) begin
      for (int r = 0; r < MaxRows; r++)
        for (int c = 0; c < MaxCols; c++) elem_mem[r][c] = '0;
      table_ready = 1'b0;
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) rows_reg = cfg_wdata;
        else cols_reg = cfg_wdata;
      end
      if (start && !busy) begin
        res = predict_rect(cur_req);
        if (cur_req.typed) begin
          res.st = cur_req.st;
          res.sum = cur_req.sum;
        end
        sum_q.push_back(res);
        n_accepted++;
        idle_cycles = 0;
      end
      if (out_valid) begin
        idle_cycles = 0;
        if (sum_q.size() == 0) begin
          $error("unexpected result: status %0d sum %0d", out_status, out_rect_sum);
          failed = 1'b1;
        end else begin
          want = sum_q.pop_front();
          if (out_status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, out_status);
            failed = 1'b1;
          end
          if (out_rect_sum !== want.sum) begin
            $error("rect_sum: expected %0d, got %0d", want.sum, out_rect_sum);
            failed = 1'b1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic req_t mk(logic [1:0] kind, logic [6:0] ra, logic [6:0] ca,
                              logic [6:0] rb, logic [6:0] cb, logic signed [15:0] val,
                              bit typed = 0, logic [1:0] st = ST_OK,
                              logic signed [27:0] sum = '0);
    req_t q;
    q.kind = kind; q.ra = ra; q.ca = ca; q.rb = rb; q.cb = cb; q.val = val;
    q.typed = typed; q.st = st; q.sum = sum;
    return q;
  endfunction

  // Index mostly within the dimension in use, sometimes anywhere in 7 bits
  function automatic logic [6:0] pick_idx(int n);
    if ($urandom_range(0, 99) < 88) return 7'($urandom_range(1, n));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic req_t rand_req(int nr, int nc);
    int p;
    req_t q;
    p = $urandom_range(0, 99);
    q = mk(REQ_LOAD, pick_idx(nr), pick_idx(nc), pick_idx(nr), pick_idx(nc),
           16'($urandom));
    if (p < 46) q.kind = REQ_LOAD;
    else if (p < 92) q.kind = REQ_QUERY;
    else if (p < 96) q.kind = REQ_BUILD;
    else q.kind = REQ_UNUSED;
    return q;
  endfunction

  // Drive one item at the falling edge and hold it until taken
  task automatic send_item(req_t q);
    int gap;
    int seen;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_req = q;
    in_req_type = q.kind;
    in_row_a = q.ra; in_col_a = q.ca; in_row_b = q.rb; in_col_b = q.cb;
    in_elem_value = q.val;
    start = 1'b1;
    seen = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sum_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    req_t plan[$];
    logic [6:0] rv, cv;
    int nr, nc;
    n_accepted = 0;
    failed = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed table at the reset dimensions
    plan.push_back(mk(REQ_QUERY, 1, 1, 1, 1, 0, 1, ST_NOTBLT, 0));
    plan.push_back(mk(REQ_QUERY, 0, 1, 3, 3, 0, 1, ST_RANGE, 0));
    plan.push_back(mk(REQ_QUERY, 65, 1, 3, 3, 0, 1, ST_RANGE, 0));
    plan.push_back(mk(REQ_LOAD, 0, 5, 0, 0, 7, 1, ST_RANGE, 0));
    plan.push_back(mk(REQ_LOAD, 5, 65, 0, 0, 7, 1, ST_RANGE, 0));
    plan.push_back(mk(REQ_LOAD, 127, 127, 0, 0, 7, 1, ST_RANGE, 0));
    plan.push_back(mk(REQ_LOAD, 1, 1, 0, 0, 16'sd32767, 1, ST_OK, 0));
    plan.push_back(mk(REQ_LOAD, 64, 64, 0, 0, -16'sd32768, 1, ST_OK, 0));
    plan.push_back(mk(REQ_LOAD, 1, 64, 0, 0, -16'sd1, 1, ST_OK, 0));
    plan.push_back(mk(REQ_LOAD, 64, 1, 0, 0, 16'sd1, 1, ST_OK, 0));
    plan.push_back(mk(REQ_UNUSED, 127, 127, 127, 127, -16'sd1, 1, ST_OK, 0));
    plan.push_back(mk(REQ_BUILD, 0, 0, 0, 0, 0, 1, ST_OK, 0));
    plan.push_back(mk(REQ_QUERY, 1, 1, 1, 1, 0, 1, ST_OK, 28'sd32767));
    plan.push_back(mk(REQ_QUERY, 64, 64, 64, 64, 0, 1, ST_OK, -28'sd32768));
    plan.push_back(mk(REQ_QUERY, 1, 1, 64, 64, 0));
    plan.push_back(mk(REQ_QUERY, 64, 64, 1, 1, 0));
    plan.push_back(mk(REQ_QUERY, 64, 1, 1, 64, 0));
    plan.push_back(mk(REQ_QUERY, 5, 3, 0, 9, 0, 1, ST_RANGE, 0));
    plan.push_back(mk(REQ_QUERY, 2, 2, 127, 2, 0, 1, ST_RANGE, 0));
    plan.push_back(mk(REQ_LOAD, 1, 1, 0, 0, 16'sd100, 1, ST_OK, 0));
    plan.push_back(mk(REQ_QUERY, 1, 1, 1, 1, 0, 1, ST_OK, 28'sd32767));
    foreach (plan[i]) send_item(plan[i]);

    // Random phases; each one opens with a build so every read entry is written
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin rv = 7'd0;   cv = 7'd0;   end
        1: begin rv = 7'd127; cv = 7'd127; end
        2: begin rv = 7'd1;   cv = 7'd64;  end
        3: begin rv = 7'd64;  cv = 7'd1;   end
        4: begin rv = 7'd64;  cv = 7'd64;  end
        default: begin
          rv = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(1, 10));
          cv = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(1, 10));
        end
      endcase
      wait_drained();
      write_cfg(CFG_ROWS, rv);
      write_cfg(CFG_COLS, cv);
      nr = eff_dim(rv);
      nc = eff_dim(cv);
      send_item(mk(REQ_BUILD, 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                   16'($urandom)));
      for (int k = 1; k < PHASE_ITEMS; k++) send_item(rand_req(nr, nc));
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
